// ----- design/sem_pkg.sv -----
package sem_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 4096;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int CfgWidthW  = 11;
  localparam int CfgHeightW = 13;
  localparam int CfgIdxW    = 1;
  localparam int PixW       = 8;
  localparam int SumW       = 12;
  localparam int SqW        = 17;
  localparam int RootW      = 9;

  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

  localparam logic [PixW-1:0] PixMax = 8'd255;

  typedef struct packed {
    logic load;
    logic step;
    logic done;
  } sem_cmd_t;

  typedef struct packed {
    logic root_done;
  } sem_sts_t;

endpackage

// ----- design/sem_ctrl.sv -----
module sem_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_free,
  input  sem_pkg::sem_sts_t  sts,
  output sem_pkg::sem_cmd_t  cmd,
  output logic               busy
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRoot = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      StIdle: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = StRoot;
        end
      end
      StRoot: begin
        cmd.step = 1'b1;
        if (sts.root_done) state_nxt = StPush;
      end
      StPush: begin
        if (out_free) begin
          cmd.done  = 1'b1;
          state_nxt = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  assign busy = (state_r != StIdle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/sem_dp.sv -----
module sem_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  logic [sem_pkg::PixW-1:0]      pixel,
  input  logic                          cfg_take,
  input  logic [sem_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [31:0]                   cfg_val,
  input  sem_pkg::sem_cmd_t             cmd,
  output sem_pkg::sem_sts_t             sts,
  output logic                          has_result,
  output logic [sem_pkg::PixW-1:0]      magnitude,
  output logic [sem_pkg::RowW-1:0]      center_row,
  output logic [sem_pkg::ColW-1:0]      center_col,
  output logic                          frame_last
);

  localparam int CntW = sem_pkg::ColW + 1;
  localparam int RcW  = sem_pkg::RowW + 1;
  localparam int SqW  = sem_pkg::SqW;
  localparam int SqXW = sem_pkg::SqW + 1;

  logic [sem_pkg::PixW-1:0] upper_mem [sem_pkg::MaxWidth];
  logic [sem_pkg::PixW-1:0] middle_mem [sem_pkg::MaxWidth];

  logic [sem_pkg::CfgWidthW-1:0]  width_r;
  logic [sem_pkg::CfgHeightW-1:0] height_r;
  logic [sem_pkg::ColW-1:0]       col_r;
  logic [sem_pkg::RowW-1:0]       row_r;
  logic [sem_pkg::PixW-1:0]       pix_r, up_r, mid_r;
  logic [sem_pkg::ColW-1:0]       wcol_r;
  logic                           rd_pend_r;
  logic [sem_pkg::PixW-1:0]       win_r [9];
  logic                           interior_r, last_r;
  logic [sem_pkg::RowW-1:0]       crow_r;
  logic [sem_pkg::ColW-1:0]       ccol_r;
  logic [sem_pkg::SqW-1:0]        rem_r;
  logic [sem_pkg::RootW-1:0]      root_r;
  logic [3:0]                     bit_r;

  logic [CntW-1:0] w_eff;
  logic [RcW-1:0]  h_eff;
  logic [CntW-1:0] col_inc;
  logic [RcW-1:0]  row_inc;
  logic signed [sem_pkg::SumW-1:0] gx_s, gy_s;
  logic [sem_pkg::PixW-1:0] gx, gy;
  logic [sem_pkg::SqW-1:0]  sq_sum;
  logic [sem_pkg::RootW-1:0] trial;
  logic [SqXW-1:0]          trial_sq;

  always_comb begin
    if (width_r < 11'd3) w_eff = CntW'(3);
    else if (width_r > 11'(sem_pkg::MaxWidth)) w_eff = CntW'(sem_pkg::MaxWidth);
    else w_eff = CntW'(width_r);
    if (height_r < 13'd3) h_eff = RcW'(3);
    else if (height_r > 13'(sem_pkg::MaxHeight)) h_eff = RcW'(sem_pkg::MaxHeight);
    else h_eff = RcW'(height_r);
  end

  assign col_inc = CntW'(col_r) + CntW'(1);
  assign row_inc = RcW'(row_r) + RcW'(1);

  always_ff @(posedge clk) begin
    if (in_take) begin
      up_r   <= upper_mem[col_r];
      mid_r  <= middle_mem[col_r];
      middle_mem[col_r] <= pixel;
      pix_r  <= pixel;
      wcol_r <= col_r;
    end
    if (rd_pend_r) upper_mem[wcol_r] <= mid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 11'd640;
      height_r   <= 13'd480;
      col_r      <= '0;
      row_r      <= '0;
      rd_pend_r  <= 1'b0;
      interior_r <= 1'b0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      rd_pend_r <= in_take;
      if (cfg_take) begin
        if (cfg_idx == sem_pkg::RegWidth) width_r <= cfg_val[sem_pkg::CfgWidthW-1:0];
        else height_r <= cfg_val[sem_pkg::CfgHeightW-1:0];
        col_r <= '0;
        row_r <= '0;
      end else if (in_take) begin
        interior_r <= (row_r >= 2) && (col_r >= 2);
        last_r     <= (row_inc == h_eff) && (col_inc == w_eff);
        crow_r     <= row_r - 1'b1;
        ccol_r     <= col_r - 1'b1;
        if (col_inc >= w_eff) begin
          col_r <= '0;
          row_r <= (row_inc >= h_eff) ? '0 : row_inc[sem_pkg::RowW-1:0];
        end else begin
          col_r <= col_inc[sem_pkg::ColW-1:0];
        end
      end
      if (rd_pend_r) begin
        win_r[0] <= win_r[1]; win_r[1] <= win_r[2]; win_r[2] <= up_r;
        win_r[3] <= win_r[4]; win_r[4] <= win_r[5]; win_r[5] <= mid_r;
        win_r[6] <= win_r[7]; win_r[7] <= win_r[8]; win_r[8] <= pix_r;
      end
    end
  end

  always_comb begin
    gx_s = $signed({4'd0, win_r[0]}) - $signed({4'd0, win_r[2]})
         + $signed({3'd0, win_r[3], 1'b0}) - $signed({3'd0, win_r[5], 1'b0})
         + $signed({4'd0, win_r[6]}) - $signed({4'd0, win_r[8]});
    gy_s = $signed({4'd0, win_r[0]}) + $signed({3'd0, win_r[1], 1'b0})
         + $signed({4'd0, win_r[2]}) - $signed({4'd0, win_r[6]})
         - $signed({3'd0, win_r[7], 1'b0}) - $signed({4'd0, win_r[8]});
    if (gx_s < 0) gx = '0;
    else if (gx_s > 12'sd255) gx = sem_pkg::PixMax;
    else gx = gx_s[sem_pkg::PixW-1:0];
    if (gy_s < 0) gy = '0;
    else if (gy_s > 12'sd255) gy = sem_pkg::PixMax;
    else gy = gy_s[sem_pkg::PixW-1:0];
    sq_sum = SqW'(gx) * SqW'(gx) + SqW'(gy) * SqW'(gy);
  end

  assign trial    = root_r | (sem_pkg::RootW'(1) << bit_r);
  assign trial_sq = SqXW'(trial) * SqXW'(trial);
  assign sts.root_done = (bit_r == 4'd0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= sq_sum;
      root_r <= '0;
      bit_r  <= 4'd8;
    end else if (cmd.step) begin
      if (trial_sq <= SqXW'(rem_r)) root_r <= trial;
      if (bit_r != 4'd0) bit_r <= bit_r - 4'd1;
    end
  end

  assign has_result = interior_r;
  assign magnitude  = (root_r > 9'd255) ? sem_pkg::PixMax : root_r[sem_pkg::PixW-1:0];
  assign center_row = crow_r;
  assign center_col = ccol_r;
  assign frame_last = last_r;

endmodule

// ----- design/sobel_edge_magnitude.sv -----
// Sobel edge magnitude, streaming 3x3 window over a raster pixel stream.
// Input channel: in_valid / in_stall / in_pixel, one 8-bit pixel per item,
// raster order. Output channel: out_valid / out_stall with magnitude,
// center_row, center_col and frame_last; one item per interior pixel,
// none for border pixels.
// Config channel: cfg_valid / cfg_ready / cfg_index / cfg_data; index 0 is
// image width, 1 is image height. A write restarts frame counting.
// Each pixel passes through the line-store read and then the window shift.
// An interior pixel then loads the bit-serial square root unit, runs it
// (one result bit per cycle) and moves the result into the output
// register once that register is free; the next pixel is accepted only
// after that move. A border pixel frees the input once it has passed the
// window shift.
// Reset (rst_n low, synchronous) restores width 640, height 480 and row
// and column 0, and empties the output register. While out_stall is high
// the result holds and the input channel stalls once the unit is busy.
module sobel_edge_magnitude (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_magnitude,
  output logic [11:0] out_center_row,
  output logic [9:0]  out_center_col,
  output logic        out_frame_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhRead = 2'd1;
  localparam logic [1:0] PhWin  = 2'd2;

  sem_pkg::sem_cmd_t cmd;
  sem_pkg::sem_sts_t sts;
  logic busy, in_take, cfg_take, has_result, start, out_free;
  logic [1:0] ph_r;
  logic [7:0]  mag;
  logic [11:0] crow;
  logic [9:0]  ccol;
  logic        flast;
  logic        out_valid_r;
  logic [7:0]  mag_r;
  logic [11:0] row_r;
  logic [9:0]  col_r;
  logic        last_r;

  assign in_stall  = busy || (ph_r != PhIdle);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid;
  assign start     = (ph_r == PhWin) && has_result;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PhIdle;
    end else begin
      case (ph_r)
        PhIdle:  if (in_take) ph_r <= PhRead;
        PhRead:  ph_r <= PhWin;
        PhWin:   ph_r <= PhIdle;
        default: ph_r <= PhIdle;
      endcase
    end
  end

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  sem_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .pixel      (in_pixel),
    .cfg_take   (cfg_take),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .has_result (has_result),
    .magnitude  (mag),
    .center_row (crow),
    .center_col (ccol),
    .frame_last (flast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      mag_r  <= mag;
      row_r  <= crow;
      col_r  <= ccol;
      last_r <= flast;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_magnitude  = mag_r;
  assign out_center_row = row_r;
  assign out_center_col = col_r;
  assign out_frame_last = last_r;

endmodule

// ----- design/sem_checker.sv -----
module sem_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_magnitude,
  input logic [11:0] out_center_row,
  input logic [9:0]  out_center_col
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_magnitude))
    else $error("result dropped under stall");

  a_take_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_center_row != 12'd0 && out_center_col != 10'd0)
    else $error("border result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_magnitude  (out_magnitude),
  .out_center_row (out_center_row),
  .out_center_col (out_center_col)
);
